// ----- rtl/gsg_pkg.sv -----
// gsg_pkg: shared widths, payload structs, sequencer codes and helpers for the
// gini split gain core. No dependencies; used by every file under rtl.
`default_nettype none

package gsg_pkg;

  localparam int IN_W   = 20;  // width of each count field
  localparam int TOT_W  = 24;  // per-side totals
  localparam int SQ_W   = 45;  // per-side sums of squares
  localparam int PROD_W = 2 * TOT_W;
  localparam int Q_W    = 16;  // Q0.16 fraction bits
  localparam int DVD_W  = 63;  // dividend / quotient width of the divider
  localparam int DVS_W  = PROD_W;
  localparam int CFG_W  = 32;
  localparam int ADDR_W = 3;

  localparam int MAX_CLASSES_DEF = 16;
  localparam int COUNT_BITS_DEF  = 20;

  localparam logic [Q_W-1:0] EMPTY_COST_RST = 16'hFFFF;

  // word select for the single register (paddr bit 2)
  localparam logic REG_EMPTY_COST = 1'b0;

  localparam int NUM_SIDES   = 3;
  localparam int SIDE_PARENT = 0;
  localparam int SIDE_LEFT   = 1;
  localparam int SIDE_RIGHT  = 2;

  typedef struct packed {
    logic [IN_W-1:0] count_parent;
    logic [IN_W-1:0] count_left;
    logic [IN_W-1:0] count_right;
    logic            last_class;
  } in_item_t;

  typedef struct packed {
    logic [Q_W-1:0] split_cost;
    logic [Q_W-1:0] info_gain;
    logic           side_empty;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ACC,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PSQ,
    ST_FINISH
  } gsg_state_t;

  typedef enum logic [1:0] {
    DIV_LEFT,
    DIV_RIGHT,
    DIV_SPLIT,
    DIV_PARENT
  } div_op_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // 1.0 - purity in Q0.16, clamped to 0..0xFFFF
  function automatic logic [Q_W-1:0] gini_q16(input logic [DVD_W-1:0] purity);
    logic [Q_W-1:0] g;
    if (purity[DVD_W-1:Q_W] != '0) begin
      g = '0;
    end else if (purity[Q_W-1:0] == '0) begin
      g = '1;
    end else begin
      g = Q_W'(0) - purity[Q_W-1:0];
    end
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gini_split_gain_core.sv -----
// gini split gain core: a non-final class takes the totals on the accepting edge,
// then makes three square-and-add passes through the shared squarer. The final class
// adds the split evaluation: up to four passes through the shared bit-serial divider
// (none when a side is empty, no parent pass when the parent total is zero).
// The result strobe lasts one cycle as busy falls; it cannot be stalled.
// Synchronous active-low reset clears the accumulators and sets empty_cost to 0xFFFF.
`default_nettype none

module gini_split_gain_core #(
  parameter int MAX_CLASSES = gsg_pkg::MAX_CLASSES_DEF,
  parameter int COUNT_BITS  = gsg_pkg::COUNT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire gsg_pkg::in_item_t          in_data,
  output logic                            busy,
  output logic                            out_valid,
  output gsg_pkg::out_item_t              out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [gsg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [gsg_pkg::CFG_W-1:0]  pwdata,
  output logic      [gsg_pkg::CFG_W-1:0]  prdata,
  output logic                            pready
);

  localparam int TW     = gsg_pkg::TOT_W;
  localparam int SW     = gsg_pkg::SQ_W;
  localparam int PW     = gsg_pkg::PROD_W;
  localparam int QW     = gsg_pkg::Q_W;
  localparam int DW     = gsg_pkg::DVD_W;
  localparam int VW     = gsg_pkg::DVS_W;
  localparam int NS     = gsg_pkg::NUM_SIDES;
  localparam int IW     = gsg_pkg::IN_W;
  localparam int CW     = (COUNT_BITS < IW) ? COUNT_BITS : IW;
  localparam int CLS_W  = $clog2(MAX_CLASSES + 1);
  localparam int SQA_W  = PW + 1;
  localparam int PP     = gsg_pkg::SIDE_PARENT;
  localparam int PL     = gsg_pkg::SIDE_LEFT;
  localparam int PR     = gsg_pkg::SIDE_RIGHT;

  gsg_pkg::gsg_state_t state_r, state_nxt;
  gsg_pkg::div_op_t    div_op_r;
  logic [CLS_W-1:0]    class_seen_r;
  logic [TW-1:0]       tot_r    [NS];
  logic [SW-1:0]       sq_sum_r [NS];
  logic [CW-1:0]       cnt_r    [NS];
  logic [1:0]          side_r;
  logic                last_r;
  logic [DW-1:0]       q_left_r, q_right_r, purity_r, pp_r;
  logic [QW-1:0]       empty_cost_r;
  logic                out_valid_r;
  gsg_pkg::out_item_t  out_data_r;

  logic                accept;
  logic                acc_en;
  logic                side_empty;
  logic                cfg_wr;
  logic [CW-1:0]       in_cnt   [NS];
  logic [TW:0]         tot_add  [NS];
  logic [TW-1:0]       tot_next [NS];
  logic [SQA_W-1:0]    sq_add;
  logic [SW-1:0]       sq_next;
  logic [TW-1:0]       sq_in;
  logic [PW-1:0]       sq_out;
  gsg_pkg::div_req_t   div_req;
  gsg_pkg::div_rsp_t   div_rsp;
  logic [QW-1:0]       cost_c, pg_c, gain_c;

  gsg_sqr u_sqr (
    .clk  (clk),
    .x    (sq_in),
    .sq_r (sq_out)
  );

  gsg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign accept     = start && !busy;
  assign acc_en     = class_seen_r < CLS_W'(MAX_CLASSES);
  assign side_empty = (tot_r[PL] == '0) || (tot_r[PR] == '0);
  assign cfg_wr     = psel && penable && pwrite && pready;

  // masked counts and saturating total updates
  always_comb begin
    in_cnt[PP] = in_data.count_parent[CW-1:0];
    in_cnt[PL] = in_data.count_left[CW-1:0];
    in_cnt[PR] = in_data.count_right[CW-1:0];
    for (int i = 0; i < NS; i++) begin
      tot_add[i]  = {1'b0, tot_r[i]} + (TW + 1)'(in_cnt[i]);
      tot_next[i] = tot_add[i][TW] ? '1 : tot_add[i][TW-1:0];
    end
  end

  always_comb begin
    sq_add  = {{(SQA_W - SW){1'b0}}, sq_sum_r[side_r]} + SQA_W'(sq_out);
    sq_next = (sq_add[SQA_W-1:SW] != '0) ? '1 : sq_add[SW-1:0];
    sq_in   = (state_r == gsg_pkg::ST_PSQ) ? tot_r[PP] : TW'(cnt_r[side_r]);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gsg_pkg::ST_IDLE: begin
        if (accept) begin
          if (acc_en) state_nxt = gsg_pkg::ST_SQ;
          else if (in_data.last_class) state_nxt = gsg_pkg::ST_CHECK;
        end
      end
      gsg_pkg::ST_SQ: state_nxt = gsg_pkg::ST_ACC;
      gsg_pkg::ST_ACC: begin
        if (side_r == 2'(NS - 1)) begin
          state_nxt = last_r ? gsg_pkg::ST_CHECK : gsg_pkg::ST_IDLE;
        end else begin
          state_nxt = gsg_pkg::ST_SQ;
        end
      end
      gsg_pkg::ST_CHECK: begin
        state_nxt = side_empty ? gsg_pkg::ST_FINISH : gsg_pkg::ST_DIV_GO;
      end
      gsg_pkg::ST_DIV_GO: state_nxt = gsg_pkg::ST_DIV_WAIT;
      gsg_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          case (div_op_r)
            gsg_pkg::DIV_LEFT,
            gsg_pkg::DIV_RIGHT: state_nxt = gsg_pkg::ST_DIV_GO;
            gsg_pkg::DIV_SPLIT: begin
              state_nxt = (tot_r[PP] == '0) ? gsg_pkg::ST_FINISH : gsg_pkg::ST_PSQ;
            end
            default: state_nxt = gsg_pkg::ST_FINISH;
          endcase
        end
      end
      gsg_pkg::ST_PSQ: state_nxt = gsg_pkg::ST_DIV_GO;
      gsg_pkg::ST_FINISH: state_nxt = gsg_pkg::ST_IDLE;
      default: state_nxt = gsg_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: divider request and result values
  always_comb begin
    busy             = (state_r != gsg_pkg::ST_IDLE);
    div_req.start    = (state_r == gsg_pkg::ST_DIV_GO);
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (div_op_r)
      gsg_pkg::DIV_LEFT: begin
        div_req.dividend = DW'({sq_sum_r[PL], {QW{1'b0}}});
        div_req.divisor  = VW'(tot_r[PL]);
      end
      gsg_pkg::DIV_RIGHT: begin
        div_req.dividend = DW'({sq_sum_r[PR], {QW{1'b0}}});
        div_req.divisor  = VW'(tot_r[PR]);
      end
      gsg_pkg::DIV_SPLIT: begin
        div_req.dividend = q_left_r + q_right_r;
        div_req.divisor  = VW'({1'b0, tot_r[PL]} + {1'b0, tot_r[PR]});
      end
      gsg_pkg::DIV_PARENT: begin
        div_req.dividend = DW'({sq_sum_r[PP], {QW{1'b0}}});
        div_req.divisor  = sq_out;
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = '0;
      end
    endcase
    cost_c = side_empty ? empty_cost_r : gsg_pkg::gini_q16(purity_r);
    pg_c   = (tot_r[PP] == '0) ? '0 : gsg_pkg::gini_q16(pp_r);
    if (side_empty || (pg_c <= cost_c)) gain_c = '0;
    else gain_c = pg_c - cost_c;
  end

  // control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gsg_pkg::ST_IDLE;
      div_op_r     <= gsg_pkg::DIV_LEFT;
      class_seen_r <= '0;
      side_r       <= '0;
      empty_cost_r <= gsg_pkg::EMPTY_COST_RST;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        tot_r[i]    <= '0;
        sq_sum_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_wr && (paddr[2] == gsg_pkg::REG_EMPTY_COST)) begin
        empty_cost_r <= pwdata[QW-1:0];
      end
      case (state_r)
        gsg_pkg::ST_IDLE: begin
          side_r   <= '0;
          div_op_r <= gsg_pkg::DIV_LEFT;
          if (accept && acc_en) begin
            class_seen_r <= class_seen_r + CLS_W'(1);
            for (int i = 0; i < NS; i++) tot_r[i] <= tot_next[i];
          end
        end
        gsg_pkg::ST_ACC: begin
          sq_sum_r[side_r] <= sq_next;
          side_r           <= side_r + 2'd1;
        end
        gsg_pkg::ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            case (div_op_r)
              gsg_pkg::DIV_LEFT:  div_op_r <= gsg_pkg::DIV_RIGHT;
              gsg_pkg::DIV_RIGHT: div_op_r <= gsg_pkg::DIV_SPLIT;
              gsg_pkg::DIV_SPLIT: div_op_r <= gsg_pkg::DIV_PARENT;
              default:            div_op_r <= gsg_pkg::DIV_LEFT;
            endcase
          end
        end
        gsg_pkg::ST_FINISH: begin
          out_valid_r  <= 1'b1;
          class_seen_r <= '0;
          for (int i = 0; i < NS; i++) begin
            tot_r[i]    <= '0;
            sq_sum_r[i] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NS; i++) cnt_r[i] <= in_cnt[i];
      last_r <= in_data.last_class;
    end
    if ((state_r == gsg_pkg::ST_DIV_WAIT) && div_rsp.done) begin
      case (div_op_r)
        gsg_pkg::DIV_LEFT:  q_left_r  <= div_rsp.quotient;
        gsg_pkg::DIV_RIGHT: q_right_r <= div_rsp.quotient;
        gsg_pkg::DIV_SPLIT: purity_r  <= div_rsp.quotient;
        default:            pp_r      <= div_rsp.quotient;
      endcase
    end
    if (state_r == gsg_pkg::ST_FINISH) begin
      out_data_r.split_cost <= cost_c;
      out_data_r.info_gain  <= gain_c;
      out_data_r.side_empty <= side_empty;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == gsg_pkg::REG_EMPTY_COST) ?
                     gsg_pkg::CFG_W'(empty_cost_r) : '0;

`ifndef SYNTHESIS
  // a result is a single-cycle strobe
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // the result leaves with the accumulators cleared and the block idle
  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == gsg_pkg::ST_IDLE) && (class_seen_r == '0))
    else $error("result without cleared accumulators");

  // a class past the limit that does not end the split is dropped at once
  a_overflow_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (class_seen_r >= CLS_W'(MAX_CLASSES)) && !in_data.last_class)
      |=> !busy)
    else $error("dropped class kept the block busy");

  // the divider only finishes while the sequencer waits on it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == gsg_pkg::ST_DIV_WAIT))
    else $error("divider finished outside the wait state");
`endif

endmodule

`default_nettype wire

// ----- rtl/gsg_sqr.sv -----
// gsg_sqr: registered squarer shared by the class-count squares and the
// parent total square. Depends on gsg_pkg.
`default_nettype none

module gsg_sqr (
  input  wire logic                       clk,
  input  wire logic [gsg_pkg::TOT_W-1:0]  x,
  output logic      [gsg_pkg::PROD_W-1:0] sq_r
);

  logic [gsg_pkg::PROD_W-1:0] sq_nxt;

  assign sq_nxt = gsg_pkg::PROD_W'(x) * gsg_pkg::PROD_W'(x);

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/gsg_div.sv -----
// gsg_div: restoring divider, one quotient bit per cycle, shared by all four
// quotients of a split. Depends on gsg_pkg for widths and request structs.
`default_nettype none

module gsg_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gsg_pkg::div_req_t req,
  output gsg_pkg::div_rsp_t      rsp
);

  localparam int DVD_W = gsg_pkg::DVD_W;
  localparam int DVS_W = gsg_pkg::DVS_W;
  localparam int CNT_W = $clog2(DVD_W);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    ge      = ~diff[DVS_W+1];
    rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DVD_W - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire
